// ----- rtl/fba_pkg.sv -----
// Shared types, constants and helpers for the file block allocator.
`default_nettype none

package fba_pkg;

   // Fixed field widths of the request and response channels
   localparam int OPCODE_W   = 2;
   localparam int SIZE_W     = 19;
   localparam int SLOT_IN_W  = 7;
   localparam int ENTRY_IN_W = 5;
   localparam int STATUS_W   = 3;
   localparam int BLKNUM_W   = 12;
   localparam int FSIZE_W    = 19;
   localparam int FREEB_W    = 26;

   // Default geometry
   localparam int DEF_TOTAL_BLOCKS    = 4096;
   localparam int DEF_BLOCK_BYTES     = 8192;
   localparam int DEF_SLOTS           = 128;
   localparam int DEF_BLOCKS_PER_FILE = 32;
   localparam int DEF_RESERVED_BLOCKS = 130;

   // Bitmap row and slot-group width
   localparam int ROW_BITS  = 32;
   localparam int ROW_BIT_W = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_LOOKUP = 2'd3
   } fba_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_NO_SLOT   = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_UNUSED    = 3'd4
   } fba_status_type;

   typedef struct packed {
      logic           accept;
      logic           clr_write;
      logic           row_inc;
      logic           grp_inc;
      logic           slot_take;
      logic           bm_rd_row;
      logic           word_load;
      logic           claim;
      logic           writeback;
      logic           free_start;
      logic           list_rd_free;
      logic           free_bm_rd;
      logic           free_wr;
      logic           slot_release;
      logic           resp_load;
      fba_status_type status;
   } fba_cmd_type;

   typedef struct packed {
      fba_op_type op;
      logic       row_last;
      logic       size_too_big;
      logic       need_too_big;
      logic       slot_ok;
      logic       grp_has_free;
      logic       grp_last;
      logic       alloc_need_zero;
      logic       slot_need_zero;
      logic       alloc_done;
      logic       word_full;
      logic       free_last;
      logic       rsp_free;
   } fba_stat_type;

   // Lowest set bit of a row: {found, index}
   function automatic logic [ROW_BIT_W:0] lowest_one(input logic [ROW_BITS-1:0] v);
      logic [ROW_BIT_W:0] r;
      r = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, ROW_BIT_W'(i)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/fba_controller.sv -----
// Sequencer for the file block allocator: clear pass, decode, allocate and free walks.
`default_nettype none

module fba_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire fba_pkg::fba_stat_type stat,
   output fba_pkg::fba_cmd_type       cmd,
   output logic                       ready
);
   import fba_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR     = 11'b000_0000_0001,
      S_IDLE      = 11'b000_0000_0010,
      S_DECODE    = 11'b000_0000_0100,
      S_SLOT_SCAN = 11'b000_0000_1000,
      S_BM_RD     = 11'b000_0001_0000,
      S_BM_LOAD   = 11'b000_0010_0000,
      S_CLAIM     = 11'b000_0100_0000,
      S_FREE_RD   = 11'b000_1000_0000,
      S_FREE_BM   = 11'b001_0000_0000,
      S_FREE_WR   = 11'b010_0000_0000,
      S_RESP      = 11'b100_0000_0000
   } fba_state_type;

   fba_state_type  state_ff, state_in;
   fba_status_type status_ff, status_in;

   always_comb begin
      cmd        = '0;
      cmd.status = status_ff;
      state_in   = state_ff;
      status_in  = status_ff;
      ready      = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            cmd.row_inc   = 1'b1;
            if (stat.row_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            state_in  = S_RESP;
            case (stat.op)
               OP_ALLOC: begin
                  if (stat.size_too_big) begin
                     status_in = ST_NO_SPACE;
                  end else if (stat.need_too_big) begin
                     status_in = ST_TOO_LARGE;
                  end else begin
                     state_in = S_SLOT_SCAN;
                  end
               end
               OP_FREE: begin
                  if (!stat.slot_ok) begin
                     status_in = ST_UNUSED;
                  end else if (stat.slot_need_zero) begin
                     cmd.slot_release = 1'b1;
                  end else begin
                     cmd.free_start = 1'b1;
                     state_in       = S_FREE_RD;
                  end
               end
               OP_LOOKUP: begin
                  if (!stat.slot_ok) begin
                     status_in = ST_UNUSED;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SLOT_SCAN: begin
            if (stat.grp_has_free) begin
               cmd.slot_take = 1'b1;
               state_in = stat.alloc_need_zero ? S_RESP : S_BM_RD;
            end else if (stat.grp_last) begin
               status_in = ST_NO_SLOT;
               state_in  = S_RESP;
            end else begin
               cmd.grp_inc = 1'b1;
            end
         end
         S_BM_RD: begin
            cmd.bm_rd_row = 1'b1;
            state_in      = S_BM_LOAD;
         end
         S_BM_LOAD: begin
            cmd.word_load = 1'b1;
            state_in      = S_CLAIM;
         end
         S_CLAIM: begin
            if (stat.alloc_done) begin
               cmd.writeback = 1'b1;
               state_in      = S_RESP;
            end else if (!stat.word_full) begin
               cmd.claim = 1'b1;
            end else begin
               cmd.writeback = 1'b1;
               cmd.row_inc   = 1'b1;
               state_in      = S_BM_RD;
            end
         end
         S_FREE_RD: begin
            cmd.list_rd_free = 1'b1;
            state_in         = S_FREE_BM;
         end
         S_FREE_BM: begin
            cmd.free_bm_rd = 1'b1;
            state_in       = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.free_wr = 1'b1;
            if (stat.free_last) begin
               cmd.slot_release = 1'b1;
               state_in         = S_RESP;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fba_datapath.sv -----
// Datapath of the file block allocator: bitmap, slot and block-list stores, counters.
`default_nettype none

module fba_datapath #(
   parameter int TOTAL_BLOCKS    = fba_pkg::DEF_TOTAL_BLOCKS,
   parameter int BLOCK_BYTES     = fba_pkg::DEF_BLOCK_BYTES,
   parameter int SLOTS           = fba_pkg::DEF_SLOTS,
   parameter int BLOCKS_PER_FILE = fba_pkg::DEF_BLOCKS_PER_FILE,
   parameter int RESERVED_BLOCKS = fba_pkg::DEF_RESERVED_BLOCKS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire fba_pkg::fba_cmd_type            cmd,
   output fba_pkg::fba_stat_type                stat,
   input  wire logic [fba_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [fba_pkg::SIZE_W-1:0]      req_size_bytes,
   input  wire logic [fba_pkg::SLOT_IN_W-1:0]   req_slot_index,
   input  wire logic [fba_pkg::ENTRY_IN_W-1:0]  req_entry_index,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic [fba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fba_pkg::SLOT_IN_W-1:0]        rsp_slot_out,
   output logic [fba_pkg::BLKNUM_W-1:0]         rsp_block_number,
   output logic                                 rsp_block_present,
   output logic [fba_pkg::FSIZE_W-1:0]          rsp_file_size,
   output logic [fba_pkg::FREEB_W-1:0]          rsp_free_bytes
);
   import fba_pkg::*;

   localparam int ROWS    = (TOTAL_BLOCKS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BLK_W   = $clog2(TOTAL_BLOCKS);
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int SGRP    = (SLOTS + ROW_BITS - 1) / ROW_BITS;
   localparam int SG_W    = (SGRP > 1) ? $clog2(SGRP) : 1;
   localparam int NEED_W  = $clog2(BLOCKS_PER_FILE + 1);
   localparam int LIST_D  = SLOTS * BLOCKS_PER_FILE;
   localparam int LIST_AW = $clog2(LIST_D);
   localparam int NUM_W   = SIZE_W + 1;
   localparam int RES_EFF = (RESERVED_BLOCKS > TOTAL_BLOCKS) ? TOTAL_BLOCKS : RESERVED_BLOCKS;
   localparam longint unsigned MAX_BYTES = longint'(TOTAL_BLOCKS) * longint'(BLOCK_BYTES);
   localparam int FB_W    = $clog2(MAX_BYTES + 1);
   localparam longint unsigned FREE0 =
      longint'(TOTAL_BLOCKS - RES_EFF) * longint'(BLOCK_BYTES);

   // Request capture
   fba_op_type               op_ff;
   logic [SIZE_W-1:0]        size_ff;
   logic [SLOT_IN_W-1:0]     slot_idx_ff;
   logic [ENTRY_IN_W-1:0]    entry_ff;
   logic [NUM_W-1:0]         need_full_ff;
   logic [NEED_W-1:0]        need_ff;

   // Walk state
   logic [NEED_W-1:0]        cnt_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [SG_W-1:0]          grp_ff;
   logic [SLOT_W-1:0]        found_ff;
   logic [ROW_BITS-1:0]      word_ff;
   logic [BLK_W-1:0]         blk_ff;
   logic [FB_W-1:0]          free_bytes_ff;
   logic [SLOTS-1:0]         slot_used_ff;

   // Stores
   logic [ROW_BITS-1:0]      bm_mem [ROWS];
   logic [ROW_BITS-1:0]      bm_rd_ff;
   logic [SIZE_W-1:0]        slot_size_mem [SLOTS];
   logic [NEED_W-1:0]        slot_need_mem [SLOTS];
   logic [SIZE_W-1:0]        slot_size_rd_ff;
   logic [NEED_W-1:0]        slot_need_rd_ff;
   logic [BLK_W-1:0]         list_mem [LIST_D];
   logic [BLK_W-1:0]         list_rd_ff;

   // Response registers
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [SLOT_IN_W-1:0]     rsp_slot_ff;
   logic [BLKNUM_W-1:0]      rsp_blk_ff;
   logic                     rsp_present_ff;
   logic [FSIZE_W-1:0]       rsp_fsize_ff;
   logic [FREEB_W-1:0]       rsp_free_ff;
   logic [SLOT_IN_W-1:0]     rsp_slot_in;
   logic [BLKNUM_W-1:0]      rsp_blk_in;
   logic                     rsp_present_in;
   logic [FSIZE_W-1:0]       rsp_fsize_in;

   logic [NUM_W-1:0]         need_num;
   logic [NUM_W-1:0]         need_calc;
   logic [SLOT_W-1:0]        req_slot_sel;
   logic [LIST_AW-1:0]       req_list_addr;
   logic [SLOT_W-1:0]        slot_sel;
   logic                     slot_in_range;
   logic [LIST_AW-1:0]       free_list_addr;
   logic [LIST_AW-1:0]       claim_list_addr;
   logic [ROW_BIT_W:0]       word_lz;
   logic [BLK_W-1:0]         claim_blk;
   logic [SGRP*ROW_BITS-1:0] used_pad;
   logic [ROW_BITS-1:0]      grp_free;
   logic [ROW_BIT_W:0]       grp_lf;
   logic [SLOT_W-1:0]        found_slot;
   logic [ROW_BITS-1:0]      clr_mask;
   logic                     bm_we;
   logic [ROW_W-1:0]         bm_wa;
   logic [ROW_BITS-1:0]      bm_wd;
   logic                     bm_re;
   logic [ROW_W-1:0]         bm_ra;
   logic [ROW_W-1:0]         blk_row;
   logic [ROW_BITS-1:0]      blk_bit;
   logic                     lk_present;
   logic [31:0]              blk_wide;
   logic [31:0]              found_wide;
   logic [63:0]              fb_wide;

   assign need_num  = NUM_W'(req_size_bytes) + NUM_W'(BLOCK_BYTES - 1);
   assign need_calc = NUM_W'(need_num / BLOCK_BYTES);

   assign req_slot_sel  = SLOT_W'(req_slot_index);
   assign req_list_addr = LIST_AW'(32'(req_slot_sel) * BLOCKS_PER_FILE + 32'(req_entry_index));

   assign slot_sel      = SLOT_W'(slot_idx_ff);
   assign slot_in_range = 32'(slot_idx_ff) < SLOTS;

   assign free_list_addr  = LIST_AW'(32'(slot_sel) * BLOCKS_PER_FILE + 32'(cnt_ff));
   assign claim_list_addr = LIST_AW'(32'(found_ff) * BLOCKS_PER_FILE + 32'(cnt_ff));

   assign word_lz   = lowest_one(~word_ff);
   assign claim_blk = BLK_W'(32'(row_ff) * ROW_BITS + 32'(word_lz[ROW_BIT_W-1:0]));

   // Slots beyond the configured count read as used
   always_comb begin
      used_pad              = '1;
      used_pad[SLOTS-1:0]   = slot_used_ff;
   end
   assign grp_free   = ~used_pad[grp_ff * ROW_BITS +: ROW_BITS];
   assign grp_lf     = lowest_one(grp_free);
   assign found_slot = SLOT_W'(32'(grp_ff) * ROW_BITS + 32'(grp_lf[ROW_BIT_W-1:0]));

   // Reset image of a bitmap row: reserved blocks and padding past the end are used
   always_comb begin
      for (int i = 0; i < ROW_BITS; i++) begin
         clr_mask[i] = (32'(row_ff) * ROW_BITS + i < RES_EFF) ||
                       (32'(row_ff) * ROW_BITS + i >= TOTAL_BLOCKS);
      end
   end

   assign blk_row = ROW_W'(blk_ff >> ROW_BIT_W);
   assign blk_bit = ROW_BITS'(1) << blk_ff[ROW_BIT_W-1:0];

   always_comb begin
      bm_we = 1'b0;
      bm_wa = row_ff;
      bm_wd = word_ff;
      if (cmd.clr_write) begin
         bm_we = 1'b1;
         bm_wd = clr_mask;
      end else if (cmd.writeback) begin
         bm_we = 1'b1;
      end else if (cmd.free_wr) begin
         bm_we = 1'b1;
         bm_wa = blk_row;
         bm_wd = bm_rd_ff & ~blk_bit;
      end
      bm_re = cmd.bm_rd_row || cmd.free_bm_rd;
      bm_ra = cmd.free_bm_rd ? ROW_W'(list_rd_ff >> ROW_BIT_W) : row_ff;
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_wa] <= bm_wd;
      end
      if (bm_re) begin
         bm_rd_ff <= bm_mem[bm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_take) begin
         slot_size_mem[found_slot] <= size_ff;
         slot_need_mem[found_slot] <= need_ff;
      end
      if (cmd.accept) begin
         slot_size_rd_ff <= slot_size_mem[req_slot_sel];
         slot_need_rd_ff <= slot_need_mem[req_slot_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.claim) begin
         list_mem[claim_list_addr] <= claim_blk;
      end
      if (cmd.accept) begin
         list_rd_ff <= list_mem[req_list_addr];
      end else if (cmd.list_rd_free) begin
         list_rd_ff <= list_mem[free_list_addr];
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= fba_op_type'(req_opcode);
         size_ff      <= req_size_bytes;
         slot_idx_ff  <= req_slot_index;
         entry_ff     <= req_entry_index;
         need_full_ff <= need_calc;
         need_ff      <= NEED_W'(need_calc);
         grp_ff       <= '0;
      end
      if (cmd.grp_inc) begin
         grp_ff <= grp_ff + 1'b1;
      end
      if (cmd.slot_take) begin
         found_ff <= found_slot;
         cnt_ff   <= '0;
      end
      if (cmd.free_start) begin
         need_ff <= slot_need_rd_ff;
         cnt_ff  <= '0;
      end
      if (cmd.claim || cmd.free_wr) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.word_load) begin
         word_ff <= bm_rd_ff;
      end else if (cmd.claim) begin
         word_ff[word_lz[ROW_BIT_W-1:0]] <= 1'b1;
      end
      if (cmd.free_bm_rd) begin
         blk_ff <= list_rd_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         free_bytes_ff <= FB_W'(FREE0);
         slot_used_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.slot_take) begin
            row_ff <= '0;
         end else if (cmd.row_inc) begin
            row_ff <= (32'(row_ff) == ROWS - 1) ? '0 : row_ff + 1'b1;
         end
         if (cmd.claim) begin
            free_bytes_ff <= free_bytes_ff - FB_W'(BLOCK_BYTES);
         end else if (cmd.free_wr) begin
            free_bytes_ff <= free_bytes_ff + FB_W'(BLOCK_BYTES);
         end
         if (cmd.slot_take) begin
            slot_used_ff[found_slot] <= 1'b1;
         end
         if (cmd.slot_release) begin
            slot_used_ff[slot_sel] <= 1'b0;
         end
         if (cmd.resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign lk_present = (32'(entry_ff) < BLOCKS_PER_FILE) &&
                       (32'(entry_ff) < 32'(slot_need_rd_ff));
   assign blk_wide   = 32'(list_rd_ff);
   assign found_wide = 32'(found_ff);
   assign fb_wide    = 64'(free_bytes_ff);

   // Response fields by opcode; zero where the opcode does not report them
   always_comb begin
      rsp_slot_in    = '0;
      rsp_blk_in     = '0;
      rsp_present_in = 1'b0;
      rsp_fsize_in   = '0;
      case (op_ff)
         OP_ALLOC: begin
            if (cmd.status == ST_OK) begin
               rsp_slot_in = found_wide[SLOT_IN_W-1:0];
            end
         end
         OP_FREE: begin
            rsp_slot_in = slot_idx_ff;
         end
         OP_LOOKUP: begin
            rsp_slot_in = slot_idx_ff;
            if (cmd.status == ST_OK) begin
               rsp_fsize_in   = slot_size_rd_ff;
               rsp_present_in = lk_present;
               if (lk_present) begin
                  rsp_blk_in = blk_wide[BLKNUM_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_status_ff  <= cmd.status;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_blk_ff     <= rsp_blk_in;
         rsp_present_ff <= rsp_present_in;
         rsp_fsize_ff   <= rsp_fsize_in;
         rsp_free_ff    <= fb_wide[FREEB_W-1:0];
      end
   end

   always_comb begin
      stat                 = '0;
      stat.op              = op_ff;
      stat.row_last        = 32'(row_ff) == ROWS - 1;
      stat.size_too_big    = 64'(size_ff) > 64'(free_bytes_ff);
      stat.need_too_big    = 32'(need_full_ff) > BLOCKS_PER_FILE;
      stat.slot_ok         = slot_in_range && slot_used_ff[slot_sel];
      stat.grp_has_free    = grp_lf[ROW_BIT_W];
      stat.grp_last        = 32'(grp_ff) == SGRP - 1;
      stat.alloc_need_zero = need_ff == '0;
      stat.slot_need_zero  = slot_need_rd_ff == '0;
      stat.alloc_done      = cnt_ff == need_ff;
      stat.word_full       = !word_lz[ROW_BIT_W];
      stat.free_last       = 32'(cnt_ff) + 1 == 32'(need_ff);
      stat.rsp_free        = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_out      = rsp_slot_ff;
   assign rsp_block_number  = rsp_blk_ff;
   assign rsp_block_present = rsp_present_ff;
   assign rsp_file_size     = rsp_fsize_ff;
   assign rsp_free_bytes    = rsp_free_ff;

endmodule

`default_nettype wire

// ----- rtl/file_block_allocator_unit.sv -----
// Top level of the file block allocator: controller, datapath and checks.
//
// Usage: one request channel (req_*) carries an opcode with a size, slot and
// list entry; one response channel (rsp_*) returns one response per request.
// A request is taken on a rising edge with req_valid high and req_stall low;
// a response is taken with rsp_valid high and rsp_stall low.
// Opcodes: allocate, free a slot, query free bytes, look up a block-list entry.
// Query and lookup answer straight after decode, as do allocates refused for
// size and frees refused; an allocate scans slot groups, then reads, fills and
// writes back bitmap rows until its blocks are taken; a free reads each list
// entry of the slot and its bitmap row, then clears that block's bit.
// The bitmap is held in 32-bit rows in one memory, and an allocate reads and
// writes back each row it walks; one request is in flight at a time.
// A finished response sits in its output register, and the next request is
// taken while it waits. A stalled receiver holds that register; a further
// response then waits in the sequencer until the register empties.
// Reset: synchronous, active high. After reset a clearing pass writes every
// bitmap row (TOTAL_BLOCKS / 32 rows, rounded up) with req_stall high.
`default_nettype none

module file_block_allocator_unit #(
   parameter int TOTAL_BLOCKS    = fba_pkg::DEF_TOTAL_BLOCKS,
   parameter int BLOCK_BYTES     = fba_pkg::DEF_BLOCK_BYTES,
   parameter int SLOTS           = fba_pkg::DEF_SLOTS,
   parameter int BLOCKS_PER_FILE = fba_pkg::DEF_BLOCKS_PER_FILE,
   parameter int RESERVED_BLOCKS = fba_pkg::DEF_RESERVED_BLOCKS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [fba_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [fba_pkg::SIZE_W-1:0]      req_size_bytes,
   input  wire logic [fba_pkg::SLOT_IN_W-1:0]   req_slot_index,
   input  wire logic [fba_pkg::ENTRY_IN_W-1:0]  req_entry_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [fba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fba_pkg::SLOT_IN_W-1:0]        rsp_slot_out,
   output logic [fba_pkg::BLKNUM_W-1:0]         rsp_block_number,
   output logic                                 rsp_block_present,
   output logic [fba_pkg::FSIZE_W-1:0]          rsp_file_size,
   output logic [fba_pkg::FREEB_W-1:0]          rsp_free_bytes
);
   import fba_pkg::*;

   fba_cmd_type  cmd;
   fba_stat_type stat;
   logic         ready;

   // Sequencer: owns the order of every memory access
   fba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .ready     (ready)
   );

   // Stores, counters and the response register
   fba_datapath #(
      .TOTAL_BLOCKS    (TOTAL_BLOCKS),
      .BLOCK_BYTES     (BLOCK_BYTES),
      .SLOTS           (SLOTS),
      .BLOCKS_PER_FILE (BLOCKS_PER_FILE),
      .RESERVED_BLOCKS (RESERVED_BLOCKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_size_bytes    (req_size_bytes),
      .req_slot_index    (req_slot_index),
      .req_entry_index   (req_entry_index),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_block_number  (rsp_block_number),
      .rsp_block_present (rsp_block_present),
      .rsp_file_size     (rsp_file_size),
      .rsp_free_bytes    (rsp_free_bytes)
   );

   // Hold off requests unless the sequencer is waiting for one
   assign req_stall = !ready;

   // Busy in the cycle after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous request still in progress");

   // A present block only ever comes with a good status
   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_present) |-> (rsp_status == ST_OK))
      else $error("block present on a failed response");

   // A response is loaded only when the output register is free
   a_resp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> (!rsp_valid || !rsp_stall))
      else $error("response overwrote a stalled response");

endmodule

`default_nettype wire
